// File: sv/binding_cache_table_defines.svh
// assertion macros for the binding cache table
// no dependencies
`ifndef BINDING_CACHE_TABLE_DEFINES_SVH
`define BINDING_CACHE_TABLE_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define BCT_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define BCT_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

// File: sv/bct_pkg.sv
// types and constants shared by the binding cache table
// no dependencies
package bct_pkg;
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_FIND_HOME = 3'd1;
  localparam logic [2:0] OP_FIND_COA = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_TICK = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_WRITE, S_DONE
  } state_t;

  typedef struct packed {
    logic [63:0] kh;
    logic [63:0] kl;
    logic [63:0] ch;
    logic [63:0] cl;
    logic [31:0] life;
  } entry_t;
endpackage

// File: sv/bct_mem.sv
// entry memory of the binding cache table: one write port, one registered read port
// depends on bct_pkg
module bct_mem #(
  parameter int ENTRIES = 16,
  parameter int AW = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  bct_pkg::entry_t wdata,
  input  logic [AW-1:0]  raddr,
  output bct_pkg::entry_t rdata
);
  import bct_pkg::*;
  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/binding_cache_table.sv
// binding cache table: ENTRIES bindings of home address, care-of address and
// lifetime, held in one synchronous memory that is scanned one slot per cycle.
// every command (start while busy is low) walks all slots: the read of slot i is
// issued in one cycle and compared in the next; after the last compare the result
// is registered in S_WRITE and done is shown in S_DONE; busy falls as done falls,
// and the next command is taken only once the table is back in S_IDLE.
// the scan is paced by the single read port of the entry memory. a tick writes
// each lowered lifetime back in the cycle its slot is compared; an insert writes its
// one slot and a remove clears its valid bit after the scan. the result comes
// with a one-cycle done; the receiver cannot stall it, so read it at that edge.
// valid bits live in flip-flops and are cleared by reset, so no clearing pass.
// depends on bct_pkg and binding_cache_table_defines.svh
`include "binding_cache_table_defines.svh"
module binding_cache_table #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  op,
  input  logic [63:0] home_addr_high,
  input  logic [63:0] home_addr_low,
  input  logic [63:0] careof_addr_high,
  input  logic [63:0] careof_addr_low,
  input  logic [31:0] lifetime_in,
  input  logic [15:0] tick_amount,
  output logic        done,
  output logic [1:0]  status,
  output logic [63:0] found_home_high,
  output logic [63:0] found_home_low,
  output logic [63:0] found_careof_high,
  output logic [63:0] found_careof_low,
  output logic [31:0] lifetime_left,
  output logic [4:0]  expired_count
);
  import bct_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = AW + 1;

  state_t state, state_next;

  // latched command
  logic [2:0]  cmd_op;
  logic [63:0] cmd_hh, cmd_hl, cmd_ch, cmd_cl;
  logic [31:0] cmd_life;
  logic [15:0] cmd_amt;

  logic [ENTRIES-1:0] valid;
  logic [CW-1:0] rd_cnt;      // next slot to read
  logic          cmp_vld;     // read data of cmp_idx is present
  logic [AW-1:0] cmp_idx;

  // scan results
  logic          hit;
  logic [AW-1:0] hit_idx;
  entry_t        best;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic [4:0]    dropped;

  entry_t rdata, wdata;
  logic   we;
  logic [AW-1:0] waddr;

  bct_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rd_cnt[AW-1:0]), .rdata(rdata)
  );

  // compare stage
  logic key_eq, coa_eq, key_less, slot_v, life_gt;
  always_comb begin
    slot_v   = valid[cmp_idx];
    key_eq   = (rdata.kh == cmd_hh) && (rdata.kl == cmd_hl);
    coa_eq   = (rdata.ch == cmd_ch) && (rdata.cl == cmd_cl);
    key_less = (rdata.kh < best.kh) || ((rdata.kh == best.kh) && (rdata.kl < best.kl));
    life_gt  = rdata.life > {16'd0, cmd_amt};
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) state_next = S_SCAN;
      S_SCAN:  if (cmp_vld && cmp_idx == AW'(ENTRIES - 1)) state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory write: tick write-back during scan, insert at the end
  always_comb begin
    we    = 1'b0;
    waddr = cmp_idx;
    wdata = rdata;
    wdata.life = rdata.life - {16'd0, cmd_amt};
    if (state == S_SCAN && cmp_vld && cmd_op == OP_TICK && slot_v && life_gt) begin
      we = 1'b1;
    end else if (state == S_WRITE && cmd_op == OP_INSERT && (hit || free_found)) begin
      we    = 1'b1;
      waddr = hit ? hit_idx : free_idx;
      wdata = '{kh: cmd_hh, kl: cmd_hl, ch: cmd_ch, cl: cmd_cl, life: cmd_life};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid   <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_op <= op; cmd_hh <= home_addr_high; cmd_hl <= home_addr_low;
            cmd_ch <= careof_addr_high; cmd_cl <= careof_addr_low;
            cmd_life <= lifetime_in; cmd_amt <= tick_amount;
            rd_cnt <= '0; cmp_vld <= 1'b0;
            hit <= 1'b0; free_found <= 1'b0; dropped <= '0;
          end
        end
        S_SCAN: begin
          // issue reads
          if (rd_cnt != CW'(ENTRIES)) begin
            rd_cnt  <= rd_cnt + 1'b1;
            cmp_idx <= rd_cnt[AW-1:0];
            cmp_vld <= 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
          if (cmp_vld) begin
            if (!slot_v && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
            if (slot_v) begin
              priority case (cmd_op)
                OP_INSERT, OP_FIND_HOME, OP_REMOVE: begin
                  if (key_eq && !hit) begin
                    hit <= 1'b1; hit_idx <= cmp_idx; best <= rdata;
                  end
                end
                OP_FIND_COA: begin
                  if (coa_eq && (!hit || key_less)) begin
                    hit <= 1'b1; hit_idx <= cmp_idx; best <= rdata;
                  end
                end
                OP_TICK: begin
                  if (!life_gt) begin
                    valid[cmp_idx] <= 1'b0;
                    if (dropped != 5'd31) dropped <= dropped + 5'd1;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_WRITE: begin
          done <= 1'b1;
          status <= ST_MISS;
          found_home_high <= '0; found_home_low <= '0;
          found_careof_high <= '0; found_careof_low <= '0;
          lifetime_left <= '0; expired_count <= '0;
          priority case (cmd_op)
            OP_INSERT: begin
              if (hit || free_found) begin
                valid[hit ? hit_idx : free_idx] <= 1'b1;
                status <= ST_OK;
                found_home_high <= cmd_hh; found_home_low <= cmd_hl;
                found_careof_high <= cmd_ch; found_careof_low <= cmd_cl;
                lifetime_left <= cmd_life;
              end else begin
                status <= ST_FULL;
              end
            end
            OP_FIND_HOME, OP_FIND_COA, OP_REMOVE: begin
              if (hit) begin
                status <= ST_OK;
                found_home_high <= best.kh; found_home_low <= best.kl;
                found_careof_high <= best.ch; found_careof_low <= best.cl;
                lifetime_left <= best.life;
                if (cmd_op == OP_REMOVE) valid[hit_idx] <= 1'b0;
              end
            end
            OP_TICK: begin
              status <= ST_OK;
              expired_count <= dropped;
            end
            default: ;
          endcase
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  `BCT_ASSERT_NEXT(a_done_after_write, clk, rst, state == S_WRITE, done, "done missing after scan")
  `BCT_ASSERT_IMP(a_done_busy, clk, rst, done, busy, "result shown while idle")
  `BCT_ASSERT_IMP(a_full_no_free, clk, rst, done && status == ST_FULL, &valid, "full with a free slot")
endmodule

// File: tb/sv/tb.sv
// testbench for the binding cache table: directed and random commands, results
// checked against a behavioral copy of the table held in a scoreboard class
// depends on bct_pkg and binding_cache_table
`timescale 1ns / 1ps
module tb;
  import bct_pkg::*;

  localparam int NSLOT = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] hh, hl, ch, cl;
    logic [31:0] life;
    logic [4:0]  expired;
  } binding_result_t;

  // behavioral binding table plus the queue of results still owed
  class binding_board;
    bit          live [NSLOT];
    logic [63:0] kh [NSLOT], kl [NSLOT], coh [NSLOT], col [NSLOT];
    logic [31:0] life [NSLOT];
    binding_result_t owed [$];
    int errors;

    function int find_key(logic [63:0] h, logic [63:0] l);
      for (int i = 0; i < NSLOT; i++)
        if (live[i] && kh[i] == h && kl[i] == l) return i;
      return -1;
    endfunction

    function void note_command(logic [2:0] op, logic [63:0] h, logic [63:0] l,
                               logic [63:0] c1, logic [63:0] c0, logic [31:0] lt,
                               logic [15:0] amt);
      binding_result_t r;
      int slot;
      r = '{ST_MISS, 0, 0, 0, 0, 0, 0};
      slot = -1;
      case (op)
        OP_INSERT: begin
          slot = find_key(h, l);
          if (slot < 0)
            for (int i = 0; i < NSLOT; i++)
              if (!live[i]) begin
                slot = i;
                break;
              end
          if (slot < 0) r.status = ST_FULL;
          else begin
            live[slot] = 1; kh[slot] = h; kl[slot] = l;
            coh[slot] = c1; col[slot] = c0; life[slot] = lt;
          end
        end
        OP_FIND_HOME, OP_REMOVE: slot = find_key(h, l);
        OP_FIND_COA: begin
          // smallest home address among care-of matches
          for (int i = 0; i < NSLOT; i++)
            if (live[i] && coh[i] == c1 && col[i] == c0)
              if (slot < 0 || {kh[i], kl[i]} < {kh[slot], kl[slot]}) slot = i;
        end
        OP_TICK: begin
          r.status = ST_OK;
          for (int i = 0; i < NSLOT; i++)
            if (live[i]) begin
              if (life[i] > amt) life[i] -= amt;
              else begin
                live[i] = 0;
                r.expired++;
              end
            end
        end
        default: ;
      endcase
      if (slot >= 0 && r.status != ST_FULL) begin
        r.status = ST_OK;
        r.hh = kh[slot]; r.hl = kl[slot]; r.ch = coh[slot]; r.cl = col[slot];
        r.life = life[slot];
        if (op == OP_REMOVE) live[slot] = 0;
      end
      owed.push_back(r);
    endfunction

    function void check_result(binding_result_t got);
      binding_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d", got.status);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp st=%0d h=%h%h c=%h%h l=%h x=%0d",
                   want.status, want.hh, want.hl, want.ch, want.cl, want.life,
                   want.expired);
          $display("          got st=%0d h=%h%h c=%h%h l=%h x=%0d",
                   got.status, got.hh, got.hl, got.ch, got.cl, got.life, got.expired);
        end
      end
    endfunction
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic [2:0] op = '0;
  logic [63:0] home_addr_high = '0, home_addr_low = '0;
  logic [63:0] careof_addr_high = '0, careof_addr_low = '0;
  logic [31:0] lifetime_in = '0;
  logic [15:0] tick_amount = '0;
  logic busy, done;
  logic [1:0] status;
  logic [63:0] found_home_high, found_home_low, found_careof_high, found_careof_low;
  logic [31:0] lifetime_left;
  logic [4:0] expired_count;

  binding_board board = new();
  logic [63:0] pool_h [8], pool_c [4];
  bit quiet;

  binding_cache_table uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // every strobed result is taken at the rising edge
  always @(posedge clk)
    if (!rst && done)
      board.check_result('{status, found_home_high, found_home_low, found_careof_high,
                           found_careof_low, lifetime_left, expired_count});

  // one command transfer: drive at the falling edge, hold until accepted;
  // start stays high between back to back commands and drops for a gap and after the last command
  task automatic send_command(logic [2:0] o, logic [63:0] h, logic [63:0] l,
                              logic [63:0] c1, logic [63:0] c0, logic [31:0] lt,
                              logic [15:0] amt);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 17)) : 0;
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    op <= o; home_addr_high <= h; home_addr_low <= l;
    careof_addr_high <= c1; careof_addr_low <= c0;
    lifetime_in <= lt; tick_amount <= amt; start <= 1;
    do @(posedge clk); while (busy);
    board.note_command(o, h, l, c1, c0, lt, amt);
    @(negedge clk);
  endtask

  // random command biased toward a small pool of keys so hits, full and ties occur
  task automatic random_command();
    logic [2:0] o;
    logic [63:0] h, l, c1, c0;
    int pick;
    pick = $urandom_range(0, 99);
    o = pick < 40 ? OP_INSERT : pick < 55 ? OP_FIND_HOME : pick < 70 ? OP_FIND_COA :
        pick < 83 ? OP_REMOVE : pick < 97 ? OP_TICK : 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) begin
      h = {$urandom, $urandom}; l = {$urandom, $urandom};
    end else begin
      h = pool_h[$urandom_range(0, 7)]; l = 64'($urandom_range(0, 5));
    end
    if ($urandom_range(0, 9) == 0) begin
      c1 = {$urandom, $urandom}; c0 = {$urandom, $urandom};
    end else begin
      c1 = pool_c[$urandom_range(0, 3)]; c0 = ~c1;
    end
    send_command(o, h, l, c1, c0,
                 $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 600),
                 $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 120)));
  endtask

  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    for (int i = 0; i < 8; i++) pool_h[i] = {$urandom, $urandom};
    pool_h[0] = '0; pool_h[1] = '1;
    for (int i = 0; i < 4; i++) pool_c[i] = {$urandom, $urandom};
    quiet = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: misses on empty table, extremes, fill to full, ties, tick edges
    send_command(OP_FIND_HOME, '1, '1, '0, '0, '0, '0);
    send_command(OP_TICK, '0, '0, '0, '0, '0, '1);
    send_command(OP_INSERT, '1, '1, '1, '1, '1, '0);
    send_command(OP_INSERT, '0, '0, '1, '1, '0, '0);
    send_command(OP_INSERT, '0, '0, '1, '1, 32'd5, '0);
    for (int i = 2; i < 17; i++)
      send_command(OP_INSERT, 64'(i), '1, '1, '1, 32'(i), '0);
    send_command(OP_FIND_COA, '0, '0, '1, '1, '0, '0);
    send_command(OP_REMOVE, '0, '0, '0, '0, '0, '0);
    send_command(3'd7, '1, '1, '1, '1, '1, '1);
    send_command(OP_TICK, '0, '0, '0, '0, '0, 16'd5);
    send_command(OP_TICK, '0, '0, '0, '0, '0, 16'hffff);
    for (int n = 0; n < 1750; n++) begin
      if (n > 1500) quiet = 1;
      random_command();
    end
    start <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
